FILE: rtl/hbr_pkg.sv
// ============================================================================
// hbr_pkg - shared types and constants for the byte-range parser
// Widths, status codes, the front-to-back queue entry and queue status.
// ============================================================================
`default_nettype none

package hbr_pkg;

    localparam int CHAR_W      = 8;
    localparam int NUM_W       = 31;
    localparam int OUT_W       = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [NUM_W-1:0] NUM_MAX = '1;

    typedef enum logic [1:0] {
        ST_VALID     = 2'd0,
        ST_IGNORED   = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

    // One parsed header, as the front hands it to the back
    typedef struct packed {
        t_status          status;
        logic [NUM_W-1:0] first_num;
        logic             first_pres;
        logic [NUM_W-1:0] second_num;
        logic             second_pres;
    } t_summary;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

FILE: rtl/hbr_if.sv
// ============================================================================
// hbr_if - channel interfaces of the byte-range parser
// Character input, result output and resource-size write channels.
// ============================================================================
`default_nettype none

interface hbr_in_if;
    logic                       valid;
    logic                       ready;
    logic [hbr_pkg::CHAR_W-1:0] header_char;
    logic                       last_char;

    modport source (output valid, output header_char, output last_char, input ready);
    modport sink   (input valid, input header_char, input last_char, output ready);
endinterface

interface hbr_out_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [hbr_pkg::OUT_W-1:0] start_offset;
    logic [hbr_pkg::OUT_W-1:0] byte_count;

    modport source (output valid, output status, output start_offset, output byte_count,
                    input ready);
    modport sink   (input valid, input status, input start_offset, input byte_count,
                    output ready);
endinterface

interface hbr_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [hbr_pkg::NUM_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/hbr_front.sv
// ============================================================================
// hbr_front - character parser
// Walks the header one character per cycle while the queue has room and
// pushes a parse summary into the queue on the final character.
// ============================================================================
`default_nettype none

module hbr_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    hbr_in_if.sink                 i_in,
    input  wire hbr_pkg::t_q_stat  i_q_stat,
    output logic                   o_push,
    output hbr_pkg::t_summary      o_push_data
);
    import hbr_pkg::*;

    typedef enum logic [2:0] {
        PH_LEAD, PH_TOKEN, PH_SKIP, PH_FIRST, PH_SECOND, PH_IGNORE
    } t_phase;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [2:0]        TOKEN_LEN = 3'd5;

    function automatic logic [CHAR_W-1:0] tok_char(input logic [2:0] pos);
        logic [CHAR_W-1:0] c;
        unique case (pos)
            3'd0:    c = "b";
            3'd1:    c = "y";
            3'd2:    c = "t";
            3'd3:    c = "e";
            3'd4:    c = "s";
            default: c = '0;
        endcase
        return c;
    endfunction

    // v*10 + d, saturating
    function automatic logic [NUM_W-1:0] add_digit(input logic [NUM_W-1:0] v,
                                                   input logic [3:0]       d);
        logic [NUM_W+3:0] n;
        n = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + (NUM_W+4)'(d);
        return (n > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : n[NUM_W-1:0];
    endfunction

    t_phase           r_phase, n_phase;
    logic [2:0]       r_tok_pos, n_tok_pos;
    logic             r_mism, n_mism;
    logic [NUM_W-1:0] r_first, n_first;
    logic             r_first_pres, n_first_pres;
    logic [NUM_W-1:0] r_second, n_second;
    logic             r_second_pres, n_second_pres;
    logic             r_bad, n_bad;

    logic              accept;
    logic              cont;
    logic              is_digit;
    logic [CHAR_W-1:0] c;

    assign c        = i_in.header_char;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign i_in.ready = !i_q_stat.full;
    assign accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_phase       = r_phase;
        n_tok_pos     = r_tok_pos;
        n_mism        = r_mism;
        n_first       = r_first;
        n_first_pres  = r_first_pres;
        n_second      = r_second;
        n_second_pres = r_second_pres;
        n_bad         = r_bad;
        cont          = 1'b1;

        if (n_phase == PH_LEAD) begin
            if (c == CH_SPACE) cont = 1'b0;
            else n_phase = PH_TOKEN;
        end
        if (cont && n_phase == PH_TOKEN) begin
            cont = 1'b0;
            if (c == CH_EQ) begin
                n_phase = (r_mism || r_tok_pos != TOKEN_LEN) ? PH_IGNORE : PH_SKIP;
                if (r_tok_pos != TOKEN_LEN) n_mism = 1'b1;
            end else if (r_tok_pos >= TOKEN_LEN) begin
                n_mism = 1'b1;
            end else begin
                if (c != tok_char(r_tok_pos)) n_mism = 1'b1;
                n_tok_pos = r_tok_pos + 3'd1;
            end
        end
        if (cont && n_phase == PH_SKIP) begin
            if (c == CH_SPACE) cont = 1'b0;
            else n_phase = PH_FIRST;
        end
        if (cont && n_phase == PH_FIRST) begin
            cont = 1'b0;
            if (c == CH_DASH) begin
                n_phase = PH_SECOND;
            end else begin
                n_first_pres = 1'b1;
                if (is_digit) n_first = add_digit(r_first, c[3:0]);
                else n_bad = 1'b1;
            end
        end
        if (cont && n_phase == PH_SECOND) begin
            n_second_pres = 1'b1;
            if (is_digit) n_second = add_digit(r_second, c[3:0]);
            else n_bad = 1'b1;
        end
    end

    // Classify the finished header
    always_comb begin
        o_push_data.first_num   = n_first;
        o_push_data.first_pres  = n_first_pres;
        o_push_data.second_num  = n_second;
        o_push_data.second_pres = n_second_pres;
        if (n_phase == PH_LEAD || n_phase == PH_TOKEN || n_phase == PH_IGNORE)
            o_push_data.status = ST_IGNORED;
        else if (n_phase != PH_SECOND || n_bad || (!n_first_pres && !n_second_pres))
            o_push_data.status = ST_MALFORMED;
        else
            o_push_data.status = ST_VALID;
    end

    assign o_push = accept && i_in.last_char;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_phase       <= PH_LEAD;
            r_tok_pos     <= '0;
            r_mism        <= 1'b0;
            r_first       <= '0;
            r_first_pres  <= 1'b0;
            r_second      <= '0;
            r_second_pres <= 1'b0;
            r_bad         <= 1'b0;
        end else if (accept) begin
            r_phase       <= n_phase;
            r_tok_pos     <= n_tok_pos;
            r_mism        <= n_mism;
            r_first       <= n_first;
            r_first_pres  <= n_first_pres;
            r_second      <= n_second;
            r_second_pres <= n_second_pres;
            r_bad         <= n_bad;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hbr_queue.sv
// ============================================================================
// hbr_queue - summary queue
// Small first-in first-out store between the parser and the resolver.
// ============================================================================
`default_nettype none

module hbr_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire hbr_pkg::t_summary i_push_data,
    input  wire logic              i_pop,
    output hbr_pkg::t_summary      o_head,
    output hbr_pkg::t_q_stat       o_stat
);
    import hbr_pkg::*;

    t_summary            r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_push, do_pop;

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_AW'(1);
    endfunction

    assign o_stat.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (do_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (do_push && !do_pop)      r_count <= r_count + QUEUE_CW'(1);
            else if (do_pop && !do_push) r_count <= r_count - QUEUE_CW'(1);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hbr_back.sv
// ============================================================================
// hbr_back - range resolver
// Resolves a parse summary against the resource size into the output
// register.
// ============================================================================
`default_nettype none

module hbr_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire hbr_pkg::t_summary         i_head,
    input  wire hbr_pkg::t_q_stat          i_q_stat,
    input  wire logic [hbr_pkg::NUM_W-1:0] i_resource_size,
    output logic                           o_pop,
    hbr_out_if.source                      o_out
);
    import hbr_pkg::*;

    localparam int W_W = NUM_W + 2;

    logic                  r_valid;
    logic [1:0]            r_status;
    logic [OUT_W-1:0]      r_off, r_len;
    logic signed [W_W-1:0] w_size, w_first, w_second, w_off, w_len, w_closed;
    logic [OUT_W-1:0]      n_off, n_len;

    assign w_size   = $signed({2'b00, i_resource_size});
    assign w_first  = $signed({2'b00, i_head.first_num});
    assign w_second = $signed({2'b00, i_head.second_num});
    assign w_closed = w_second - w_first + W_W'(1);

    always_comb begin
        w_off = '0;
        w_len = '0;
        if (!i_head.first_pres) begin
            w_len = w_second;
            w_off = w_size - w_second;
        end else if (!i_head.second_pres) begin
            w_off = w_first;
            w_len = w_size - w_first;
        end else begin
            w_off = w_first;
            w_len = (w_closed > $signed({2'b00, NUM_MAX})) ? $signed({2'b00, NUM_MAX})
                                                           : w_closed;
        end
        if (i_head.status == ST_VALID) begin
            n_off = w_off[OUT_W-1:0];
            n_len = w_len[OUT_W-1:0];
        end else begin
            n_off = '0;
            n_len = '0;
        end
    end

    assign o_pop = !i_q_stat.empty && (!r_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_status <= i_head.status;
            r_off    <= n_off;
            r_len    <= n_len;
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.status       = r_status;
    assign o_out.start_offset = r_off;
    assign o_out.byte_count   = r_len;

endmodule

`default_nettype wire

FILE: rtl/http_byte_range_parser.sv
// ============================================================================
// http_byte_range_parser - single byte-range parser for a Range header
// Parses "bytes=m-n" style header values one character per item and
// reports status, start offset and byte count against the resource size.
// ============================================================================
//
//  Channel  Dir  Payload                                   Item
//  -------  ---  ----------------------------------------  ----------------------
//  i_cfg    in   data[30:0]                                resource size write
//  i_in     in   header_char[7:0], last_char               one header character
//  o_out    out  status[1:0], start_offset[31:0],          one resolved range,
//                byte_count[31:0]                          per final character
//
//  Takes one character per cycle while the queue has room; the parser
//  registers its state, with the number update (times ten plus digit),
//  on each accepted character. o_out.valid rises once the summary, pushed
//  into the queue with the final character, loads into the resolver's
//  output register; a full output register holds it in the queue.
//  Reset clears the parse state, the queue pointers and count, the output
//  valid flag and sets the resource size to 0. i_in.ready drops only while
//  the queue is full; the config channel is always ready.
// ============================================================================
`default_nettype none

module http_byte_range_parser (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hbr_cfg_if.sink    i_cfg,
    hbr_in_if.sink     i_in,
    hbr_out_if.source  o_out
);
    import hbr_pkg::*;

    logic [NUM_W-1:0] r_resource_size;
    logic             push, pop;
    t_summary         push_data, head;
    t_q_stat          q_stat;

    // Hold the resource size; the user must write it only while the block is idle, which the block does not enforce
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resource_size <= '0;
        end else if (i_cfg.valid) begin
            r_resource_size <= i_cfg.data;
        end
    end

    // Front: classify characters and build the numbers
    hbr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // Queue: decouple parser from resolver
    hbr_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    // Back: resolve the range and drive the output register
    hbr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_q_stat        (q_stat),
        .i_resource_size (r_resource_size),
        .o_pop           (pop),
        .o_out           (o_out)
    );

    // The parser never pushes into a full queue
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("summary pushed into a full queue");

    // Input stalls only because the queue is full
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> q_stat.full)
        else $error("input stalled with room in the queue");

    // A rejected header carries zero offset and count
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_VALID) |->
            (o_out.start_offset == '0 && o_out.byte_count == '0))
        else $error("rejected header with nonzero offset or count");

    // A queued summary moves into a free output register in the next cycle
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!q_stat.empty && !o_out.valid) |=> o_out.valid)
        else $error("queued summary not moved to output");

endmodule

`default_nettype wire

FILE: test/tb_http_byte_range_parser.sv
// ============================================================================
// tb_http_byte_range_parser - self-checking bench for the byte-range parser
// Streams Range header values one character per item, runs each accepted
// item through a local parser model and checks every resolved range (status,
// start offset, byte count) in order, under changing resource sizes and
// under several sender idle and receiver stall mixes.
// ============================================================================

module tb_http_byte_range_parser;
    timeunit 1ns;
    timeprecision 1ps;

    import hbr_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 5;
    // A result passes the queue, then the output register; leave some slack.
    localparam int DRAIN_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 50;

    localparam logic [7:0]       CH_SPACE   = 8'h20;
    localparam logic [7:0]       CH_EQUAL   = 8'h3D;
    localparam logic [7:0]       CH_DASH    = 8'h2D;
    localparam logic [7:0]       CH_ZERO    = 8'h30;
    localparam logic [7:0]       CH_NINE    = 8'h39;
    localparam logic [7:0]       CH_NUL     = 8'h00;
    localparam logic [7:0]       CH_ALL_ONE = 8'hFF;
    localparam logic [39:0]      TOKEN_TEXT = "bytes";
    localparam int               TOKEN_LEN  = 5;
    localparam logic [NUM_W-1:0] SIZE_MAX   = NUM_MAX;

    // Where the local parser stands inside one header value
    typedef enum logic [2:0] {
        SCAN_LEAD,      // skipping spaces before the unit token
        SCAN_TOKEN,     // matching the unit token up to '='
        SCAN_GAP,       // skipping spaces after '='
        SCAN_FROM,      // first number, up to '-'
        SCAN_TO,        // second number, up to the final character
        SCAN_DROP       // token did not match: wait for the end
    } t_scan;

    typedef logic [7:0] t_chars [$];

    typedef struct {
        t_status          status;
        logic [OUT_W-1:0] offset;
        logic [OUT_W-1:0] count;
    } t_range;

    logic clk = 1'b0;
    logic rst_n;

    hbr_in_if  in_ch ();
    hbr_out_if out_ch ();
    hbr_cfg_if cfg_ch ();

    http_byte_range_parser DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Local copy of the parser state and the resource size register
    t_scan            scan;
    int               tok_idx;
    bit               tok_bad;
    logic [NUM_W-1:0] from_val;
    bit               from_seen;
    logic [NUM_W-1:0] to_val;
    bit               to_seen;
    bit               junk_seen;
    logic [NUM_W-1:0] size_reg;

    // Resolved ranges still owed by the block, oldest first
    t_range ranges_due [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int cycle_count = 0;

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------

    // Append one decimal digit, saturating at the largest 31-bit value.
    function automatic logic [NUM_W-1:0] push_digit(logic [NUM_W-1:0] acc, logic [7:0] c);
        logic [NUM_W+4:0] wide;
        wide = {5'd0, acc} * 10 + (c - CH_ZERO);
        return (wide > NUM_MAX) ? NUM_MAX : wide[NUM_W-1:0];
    endfunction

    function automatic void clear_scan();
        scan      = SCAN_LEAD;
        tok_idx   = 0;
        tok_bad   = 1'b0;
        from_val  = '0;
        from_seen = 1'b0;
        to_val    = '0;
        to_seen   = 1'b0;
        junk_seen = 1'b0;
    endfunction

    // Advance the model by one character. A phase that finishes its job on
    // a character falls through to the next one with the same character.
    function automatic void advance_scan(logic [7:0] c);
        bit is_digit;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (scan == SCAN_LEAD) begin
            if (c == CH_SPACE) return;
            scan = SCAN_TOKEN;
        end
        if (scan == SCAN_TOKEN) begin
            if (c == CH_EQUAL) begin
                if (tok_idx != TOKEN_LEN) tok_bad = 1'b1;
                scan = tok_bad ? SCAN_DROP : SCAN_GAP;
            end else if (tok_idx >= TOKEN_LEN) begin
                tok_bad = 1'b1;
            end else begin
                if (c != TOKEN_TEXT[8*(TOKEN_LEN-1-tok_idx) +: 8]) tok_bad = 1'b1;
                tok_idx++;
            end
            return;
        end
        if (scan == SCAN_GAP) begin
            if (c == CH_SPACE) return;
            scan = SCAN_FROM;
        end
        if (scan == SCAN_FROM) begin
            if (c == CH_DASH) begin
                scan = SCAN_TO;
            end else begin
                from_seen = 1'b1;
                if (is_digit) from_val = push_digit(from_val, c);
                else junk_seen = 1'b1;
            end
            return;
        end
        if (scan == SCAN_TO) begin
            to_seen = 1'b1;
            if (is_digit) to_val = push_digit(to_val, c);
            else junk_seen = 1'b1;
        end
    endfunction

    // Turn the parse state into a status, offset and count on the final char.
    function automatic t_range resolve_range();
        t_range r;
        longint off;
        longint len;
        off = 0;
        len = 0;
        if (scan == SCAN_LEAD || scan == SCAN_TOKEN || scan == SCAN_DROP) begin
            r.status = ST_IGNORED;
        end else if (scan != SCAN_TO || junk_seen || (!from_seen && !to_seen)) begin
            r.status = ST_MALFORMED;
        end else begin
            r.status = ST_VALID;
            if (!from_seen) begin
                // suffix range: the last n bytes
                len = longint'(to_val);
                off = longint'(size_reg) - len;
            end else if (!to_seen) begin
                // open range: from m to the end
                off = longint'(from_val);
                len = longint'(size_reg) - off;
            end else begin
                off = longint'(from_val);
                len = longint'(to_val) - off + 1;
                if (len > longint'(NUM_MAX)) len = longint'(NUM_MAX);
            end
        end
        r.offset = off[OUT_W-1:0];
        r.count  = len[OUT_W-1:0];
        return r;
    endfunction

    function automatic void predict_char(logic [7:0] c, logic last);
        advance_scan(c);
        if (last) begin
            ranges_due.push_back(resolve_range());
            clear_scan();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Header text helpers
    // ------------------------------------------------------------------------

    function automatic t_chars text(string s);
        t_chars h;
        for (int i = 0; i < s.len(); i++) h.push_back(s[i]);
        return h;
    endfunction

    // Mostly short numbers, now and then long enough to saturate.
    function automatic t_chars random_digits();
        t_chars h;
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 80) n = $urandom_range(1, 4);
        else if (pick < 95) n = $urandom_range(5, 9);
        else n = $urandom_range(10, 12);
        repeat (n) h.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        return h;
    endfunction

    // Mostly well-formed byte ranges with random numbers; the rest is
    // corrupted, cut short, or plain noise.
    function automatic t_chars random_header();
        t_chars h;
        t_chars num;
        string  palette;
        int     form;
        int     keep;
        palette = "bytes =-0123456789";
        if ($urandom_range(99) < 80) begin
            repeat ($urandom_range(0, 2)) h.push_back(CH_SPACE);
            h = {h, text("bytes")};
            if ($urandom_range(99) < 6) h[$urandom_range(0, h.size() - 1)] = 8'($urandom);
            h.push_back(CH_EQUAL);
            repeat ($urandom_range(0, 1)) h.push_back(CH_SPACE);
            form = $urandom_range(0, 2);    // 0 suffix, 1 open, 2 closed
            if (form != 0) begin
                num = random_digits();
                h = {h, num};
            end
            h.push_back(CH_DASH);
            if (form != 1) begin
                num = random_digits();
                h = {h, num};
            end
            if ($urandom_range(99) < 6) h[$urandom_range(0, h.size() - 1)] = 8'($urandom);
            if ($urandom_range(99) < 4) begin
                keep = $urandom_range(1, h.size());
                h = h[0:keep-1];
            end
        end else begin
            repeat ($urandom_range(1, 10)) begin
                if ($urandom_range(1)) h.push_back(8'($urandom));
                else h.push_back(palette[$urandom_range(0, palette.len() - 1)]);
            end
        end
        return h;
    endfunction

    function automatic logic [NUM_W-1:0] random_size();
        case ($urandom_range(0, 3))
            0: return $urandom_range(1) ? SIZE_MAX : '0;
            1: return NUM_W'($urandom);
            default: return NUM_W'($urandom_range(0, 5000));
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Send one character item. Valid stays high from one item to the next;
    // it drops only during an idle gap.
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.header_char <= c;
        in_ch.last_char   <= last;
        do @(posedge clk); while (!in_ch.ready);
        predict_char(c, last);
    endtask

    task automatic send_header(input t_chars h);
        for (int i = 0; i < h.size(); i++) send_char(h[i], i == h.size() - 1);
    endtask

    task automatic send_text(input string s);
        send_header(text(s));
    endtask

    // Hold the input idle until every owed range has come back, then let
    // the pipeline settle.
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (ranges_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the resource size; call only while the block is idle.
    task automatic set_size(input logic [NUM_W-1:0] size_bytes);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= size_bytes;
        do @(posedge clk); while (!cfg_ch.ready);
        size_reg = size_bytes;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("[%0t] MISMATCH %s: got 0x%08h, expected 0x%08h", $time, what, got, want);
    endtask

    // Receiver: drop ready at random per the current stall mix.
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each accepted result item with the oldest owed range.
    always @(posedge clk) begin
        t_range want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            if (ranges_due.size() == 0) begin
                report_mismatch("result with none owed, status", 32'(out_ch.status), '0);
            end else begin
                want = ranges_due.pop_front();
                if (out_ch.status !== want.status)
                    report_mismatch("status", 32'(out_ch.status), 32'(want.status));
                if (out_ch.start_offset !== want.offset)
                    report_mismatch("start_offset", out_ch.start_offset, want.offset);
                if (out_ch.byte_count !== want.count)
                    report_mismatch("byte_count", out_ch.byte_count, want.count);
            end
        end
    end

    // Watchdog: end the run if it ever hangs.
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Resource size is still at its reset value of zero here.
    task automatic test_reset_size();
        send_text("bytes=-10");
        send_text("bytes=7-");
        send_text("bytes=0-0");
    endtask

    task automatic test_closed_ranges();
        wait_idle();
        set_size(1000);
        send_text("bytes=0-99");
        send_text("  bytes=  5-9");
        send_text("bytes=500-499");
        send_text("bytes=2147483647-0");    // end below start: negative count
    endtask

    task automatic test_open_and_suffix();
        wait_idle();
        set_size(SIZE_MAX);
        send_text("bytes=100-");
        send_text("bytes=-50");
        send_text("bytes=0-");
        wait_idle();
        set_size(100);
        // beyond the resource: differences go negative
        send_text("bytes=-3000");
        send_text("bytes=500-");
    endtask

    task automatic test_ignored_tokens();
        send_text("bytes =0-1");            // trailing space inside the token
        send_text("byte=0-1");
        send_text("bytesx=0-1");
        send_text("Bytes=0-1");
        send_text("bytes");                 // never reaches '='
        send_text(" ");
        send_text("=");
        send_text("=5-6");
    endtask

    task automatic test_malformed();
        t_chars h;
        send_text("bytes=10");              // no separator
        send_text("bytes=1a-5");
        send_text("bytes=1-2-3");           // second separator
        send_text("bytes=-");               // both numbers empty
        send_text("bytes=");
        send_text("bytes= ");
        send_text("bytes=5-x");
        h = text("bytes=1");
        h.push_back(CH_NUL);
        h = {h, text("-2")};
        send_header(h);
        h = text("bytes=");
        h.push_back(CH_ALL_ONE);
        send_header(h);
    endtask

    task automatic test_saturation();
        send_text("bytes=99999999999-");
        send_text("bytes=0-99999999999");
        send_text("bytes=-2147483648");
        send_text("bytes=2147483647-2147483647");
    endtask

    // Random headers under one idle and stall mix. Now and then hold the
    // sender until all owed ranges are back, and sometimes change the size.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int char_budget);
        t_chars h;
        int     sent;
        int     roll;
        wait_idle();
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        set_size(random_size());
        sent = 0;
        while (sent < char_budget) begin
            h = random_header();
            send_header(h);
            sent += h.size();
            roll = $urandom_range(99);
            if (roll < 4) begin
                wait_idle();
            end else if (roll < 10) begin
                wait_idle();
                set_size(random_size());
            end
        end
    endtask

    initial begin
        rst_n             <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.header_char <= '0;
        in_ch.last_char   <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        clear_scan();
        size_reg = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_size();
        test_closed_ranges();
        test_open_and_suffix();
        test_ignored_tokens();
        test_malformed();
        test_saturation();

        test_random_traffic(0, 0, 170);
        test_random_traffic(82, 0, 170);
        test_random_traffic(0, 82, 170);
        test_random_traffic(37, 37, 170);

        wait_idle();
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: http_byte_range_parser.f
rtl/hbr_pkg.sv
rtl/hbr_if.sv
rtl/hbr_front.sv
rtl/hbr_queue.sv
rtl/hbr_back.sv
rtl/http_byte_range_parser.sv
test/tb_http_byte_range_parser.sv
